// File: design/phase_tagged_ring_consumer_assert.svh
// Assertion macros shared by the ring consumer RTL.
`ifndef PHASE_TAGGED_RING_CONSUMER_ASSERT_SVH
`define PHASE_TAGGED_RING_CONSUMER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define PTRC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ptrc assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define PTRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ptrc assertion failed");
`else
`define PTRC_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define PTRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: design/ptrc_pkg.sv
// Types and constants shared by the ring consumer modules.
`default_nettype none
package ptrc_pkg;

  localparam int unsigned TAG_MSB = 31;
  localparam int unsigned TAG_LSB = 29;

  typedef enum logic {
    ACT_CONSUME = 1'b0,
    ACT_FLUSH   = 1'b1
  } ptrc_action_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNAVAILABLE = 2'd1,
    ST_REFUSED     = 2'd2,
    ST_DB_FAIL     = 2'd3
  } ptrc_status_t;

  typedef enum logic {
    CFG_DOORBELL_BASE = 1'b0,
    CFG_COUNT_ENABLE  = 1'b1
  } ptrc_cfg_idx_t;

  // One classified beat as it waits in the queue.
  typedef struct packed {
    ptrc_action_t act;
    logic [2:0]   tag;
    logic [31:0]  avail;
    logic [31:0]  seqw;
    logic         consume_ok;
    logic         write_ok;
  } ptrc_item_t;

  // Queue status seen by front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } ptrc_qstat_t;

endpackage
`default_nettype wire

// File: design/ptrc_front.sv
// Front end: accept input beats and classify them for the queue.
`default_nettype none
`include "phase_tagged_ring_consumer_assert.svh"
module ptrc_front import ptrc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [31:0] in_availability_word,
  input  wire logic [31:0] in_sequence_word,
  input  wire logic        in_consume_ok,
  input  wire logic        in_write_ok,
  input  wire ptrc_qstat_t qstat,
  output logic             push,
  output ptrc_item_t       push_item
);

  assign in_stall = qstat.full;
  assign push     = in_valid && !qstat.full;

  always_comb begin
    push_item.act        = ptrc_action_t'(in_action);
    push_item.tag        = in_availability_word[TAG_MSB:TAG_LSB];
    push_item.avail      = in_availability_word;
    push_item.seqw       = in_sequence_word;
    push_item.consume_ok = in_consume_ok;
    push_item.write_ok   = in_write_ok;
  end

  `PTRC_ASSERT_NOW(a_push_not_full, clk, rst_n, push, !qstat.full)

endmodule
`default_nettype wire

// File: design/ptrc_queue.sv
// Two-entry queue between the front and back ends.
`default_nettype none
module ptrc_queue import ptrc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire ptrc_item_t push_item,
  input  wire logic       pop,
  output ptrc_item_t      head,
  output ptrc_qstat_t     qstat
);

  ptrc_item_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign head        = mem_r[rd_ptr_r];
  assign qstat.full  = (cnt_r == 2'd2);
  assign qstat.empty = (cnt_r == 2'd0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/ptrc_back.sv
// Back end: ring state, doorbell decisions, configuration and result register.
`default_nettype none
`include "phase_tagged_ring_consumer_assert.svh"
module ptrc_back import ptrc_pkg::*; #(
  parameter int unsigned RING_DEPTH       = 256,
  parameter int unsigned PUBLISH_INTERVAL = 8,
  parameter int unsigned INDEX_OFFSET     = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire ptrc_item_t  head,
  input  wire ptrc_qstat_t qstat,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic             out_consumed,
  output logic [7:0]       out_entry_index,
  output logic [31:0]      out_entry_low,
  output logic [31:0]      out_entry_high,
  output logic             out_doorbell_write,
  output logic [31:0]      out_doorbell_address,
  output logic [7:0]       out_doorbell_value,
  output logic [7:0]       out_next_index,
  output logic [2:0]       out_expected_tag,
  output logic [31:0]      out_seen_count,
  output logic [31:0]      out_flush_count
);

  localparam logic [3:0]  PubLevel = 4'(PUBLISH_INTERVAL);
  localparam logic [31:0] RingLim  = 32'(RING_DEPTH);
  localparam logic [31:0] DbOffset = 32'(INDEX_OFFSET);

  logic [31:0] db_base_r;
  logic        cnt_en_r;

  logic [7:0]  pos_r, pos_nxt;
  logic [2:0]  gen_r, gen_nxt;
  logic [3:0]  pend_r, pend_nxt;
  logic [7:0]  last_idx_r, last_idx_nxt;
  logic        liv_r, liv_nxt;
  logic [31:0] seen_r, seen_nxt;
  logic [31:0] forced_r, forced_nxt;

  logic         out_valid_r, out_valid_nxt;
  ptrc_status_t st_r, st_nxt;
  logic         cons_r, cons_nxt;
  logic [7:0]   idx_r;
  logic [31:0]  lo_r, lo_nxt;
  logic [31:0]  hi_r, hi_nxt;
  logic         dbw_r, dbw_nxt;
  logic [31:0]  dba_r, dba_nxt;
  logic [7:0]   dbv_r, dbv_nxt;

  logic [8:0]  pos_inc;
  logic        wrap;
  logic [31:0] db_addr;
  logic [3:0]  pend_inc;
  logic        go;

  assign pop           = !qstat.empty && (!out_valid_r || !out_stall);
  assign out_valid_nxt = pop || (out_valid_r && out_stall);

  assign pos_inc  = {1'b0, pos_r} + 9'd1;
  assign wrap     = (32'(pos_inc) >= RingLim) || pos_inc[8];
  assign db_addr  = db_base_r + DbOffset;

  always_comb begin
    pos_nxt      = pos_r;
    gen_nxt      = gen_r;
    pend_nxt     = pend_r;
    last_idx_nxt = last_idx_r;
    liv_nxt      = liv_r;
    seen_nxt     = seen_r;
    forced_nxt   = forced_r;
    st_nxt       = ST_OK;
    cons_nxt     = 1'b0;
    lo_nxt       = '0;
    hi_nxt       = '0;
    dbw_nxt      = 1'b0;
    dba_nxt      = '0;
    dbv_nxt      = '0;
    go           = 1'b0;
    pend_inc     = '0;
    case (head.act)
      ACT_FLUSH: begin
        if (pend_r != 4'd0) begin
          if (!liv_r) begin
            st_nxt = ST_DB_FAIL;
          end else begin
            dbw_nxt = 1'b1;
            dba_nxt = db_addr;
            dbv_nxt = last_idx_r;
            if (head.write_ok) begin
              pend_nxt   = 4'd0;
              forced_nxt = forced_r + 32'd1;
            end else begin
              st_nxt = ST_DB_FAIL;
            end
          end
        end
      end
      ACT_CONSUME: begin
        go = 1'b1;
        // Retry an overdue doorbell before looking at the entry.
        if (pend_r >= PubLevel) begin
          if (!liv_r) begin
            go     = 1'b0;
            st_nxt = ST_DB_FAIL;
          end else begin
            dbw_nxt = 1'b1;
            dba_nxt = db_addr;
            dbv_nxt = last_idx_r;
            if (head.write_ok) begin
              pend_nxt = 4'd0;
            end else begin
              go     = 1'b0;
              st_nxt = ST_DB_FAIL;
            end
          end
        end
        if (go) begin
          if (head.tag != gen_r) begin
            st_nxt = ST_UNAVAILABLE;
          end else begin
            if (cnt_en_r) begin
              seen_nxt = seen_r + 32'd1;
            end
            lo_nxt = head.seqw;
            hi_nxt = head.avail;
            if (!head.consume_ok) begin
              st_nxt = ST_REFUSED;
            end else begin
              cons_nxt     = 1'b1;
              last_idx_nxt = pos_r;
              liv_nxt      = 1'b1;
              if (wrap) begin
                pos_nxt = 8'd0;
                gen_nxt = head.tag + 3'd1;
              end else begin
                pos_nxt = pos_inc[7:0];
              end
              pend_inc = pend_nxt + 4'd1;
              pend_nxt = pend_inc;
              if (pend_inc >= PubLevel) begin
                dbw_nxt = 1'b1;
                dba_nxt = db_addr;
                dbv_nxt = pos_r;
                if (head.write_ok) begin
                  pend_nxt = 4'd0;
                end else begin
                  st_nxt = ST_DB_FAIL;
                end
              end
            end
          end
        end
      end
      default: begin
        st_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_base_r <= '0;
      cnt_en_r  <= 1'b0;
    end else if (cfg_we) begin
      case (ptrc_cfg_idx_t'(cfg_index))
        CFG_DOORBELL_BASE: db_base_r <= cfg_data;
        CFG_COUNT_ENABLE:  cnt_en_r  <= cfg_data[0];
        default:           cnt_en_r  <= cnt_en_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      gen_r       <= '0;
      pend_r      <= '0;
      last_idx_r  <= '0;
      liv_r       <= 1'b0;
      seen_r      <= '0;
      forced_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        pos_r      <= pos_nxt;
        gen_r      <= gen_nxt;
        pend_r     <= pend_nxt;
        last_idx_r <= last_idx_nxt;
        liv_r      <= liv_nxt;
        seen_r     <= seen_nxt;
        forced_r   <= forced_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      st_r   <= st_nxt;
      cons_r <= cons_nxt;
      idx_r  <= pos_r;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      dbw_r  <= dbw_nxt;
      dba_r  <= dba_nxt;
      dbv_r  <= dbv_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = st_r;
  assign out_consumed         = cons_r;
  assign out_entry_index      = idx_r;
  assign out_entry_low        = lo_r;
  assign out_entry_high       = hi_r;
  assign out_doorbell_write   = dbw_r;
  assign out_doorbell_address = dba_r;
  assign out_doorbell_value   = dbv_r;
  assign out_next_index       = pos_r;
  assign out_expected_tag     = gen_r;
  assign out_seen_count       = seen_r;
  assign out_flush_count      = forced_r;

  `PTRC_ASSERT_NOW(a_pend_bounded, clk, rst_n, 1'b1, pend_r <= PubLevel)
  `PTRC_ASSERT_NOW(a_consumed_last_idx, clk, rst_n, out_valid_r && cons_r, last_idx_r == idx_r && liv_r)
  `PTRC_ASSERT_NEXT(a_pop_fills_out, clk, rst_n, pop, out_valid_r)
  `PTRC_ASSERT_NOW(a_consumed_status, clk, rst_n, out_valid_r && cons_r, st_r == ST_OK || st_r == ST_DB_FAIL)

endmodule
`default_nettype wire

// File: design/phase_tagged_ring_consumer.sv
// Top level of the phase-tagged descriptor ring consumer.
// Usage:
//   Input channel (in_*): one beat per descriptor read at the current ring index,
//   or a flush request (in_action = 1). A beat is taken when in_valid is high and
//   in_stall is low. The front end tags each beat and parks it in a two-entry
//   queue; the back end owns the ring index, generation tag, pending count,
//   doorbell logic and counters, and writes one result beat per input beat into
//   an output register.
//   Output channel (out_*): one result per input beat, taken when out_valid is
//   high and out_stall is low.
//   An accepted beat is stored in a queue entry and then popped into the result
//   register. Throughput: one beat per cycle while out_stall stays low.
//   Receiver stall: the result register holds; the queue absorbs up to two more
//   beats, then in_stall rises until the receiver drains.
//   Configuration (cfg_*): write doorbell_base (index 0) or count_enable
//   (index 1) only while the block is idle.
//   Reset (rst_n low, synchronous): ring state, counters, configuration and the
//   queue clear at once; no clearing pass.
`default_nettype none
module phase_tagged_ring_consumer import ptrc_pkg::*; #(
  parameter int unsigned RING_DEPTH       = 256,
  parameter int unsigned PUBLISH_INTERVAL = 8,
  parameter int unsigned INDEX_OFFSET     = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [31:0] in_availability_word,
  input  wire logic [31:0] in_sequence_word,
  input  wire logic        in_consume_ok,
  input  wire logic        in_write_ok,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic             out_consumed,
  output logic [7:0]       out_entry_index,
  output logic [31:0]      out_entry_low,
  output logic [31:0]      out_entry_high,
  output logic             out_doorbell_write,
  output logic [31:0]      out_doorbell_address,
  output logic [7:0]       out_doorbell_value,
  output logic [7:0]       out_next_index,
  output logic [2:0]       out_expected_tag,
  output logic [31:0]      out_seen_count,
  output logic [31:0]      out_flush_count
);

  ptrc_item_t  push_item;
  ptrc_item_t  head;
  ptrc_qstat_t qstat;
  logic        push;
  logic        pop;

  // Classify beats and push them while the queue has room.
  ptrc_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_action            (in_action),
    .in_availability_word (in_availability_word),
    .in_sequence_word     (in_sequence_word),
    .in_consume_ok        (in_consume_ok),
    .in_write_ok          (in_write_ok),
    .qstat                (qstat),
    .push                 (push),
    .push_item            (push_item)
  );

  // Decouple the two ends so each can stall on its own.
  ptrc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // Advance ring state and register one result per popped beat.
  ptrc_back #(
    .RING_DEPTH       (RING_DEPTH),
    .PUBLISH_INTERVAL (PUBLISH_INTERVAL),
    .INDEX_OFFSET     (INDEX_OFFSET)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .head                 (head),
    .qstat                (qstat),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_consumed         (out_consumed),
    .out_entry_index      (out_entry_index),
    .out_entry_low        (out_entry_low),
    .out_entry_high       (out_entry_high),
    .out_doorbell_write   (out_doorbell_write),
    .out_doorbell_address (out_doorbell_address),
    .out_doorbell_value   (out_doorbell_value),
    .out_next_index       (out_next_index),
    .out_expected_tag     (out_expected_tag),
    .out_seen_count       (out_seen_count),
    .out_flush_count      (out_flush_count)
  );

endmodule
`default_nettype wire

// File: tb/tb_ring_ledger_pkg.sv
// Prediction and result checking for the phase-tagged ring consumer testbench.
package tb_ring_ledger_pkg;
  import ptrc_pkg::*;

  localparam int unsigned RING_SIZE   = 256;
  localparam int unsigned PUBLISH_AT  = 8;
  localparam int unsigned BELL_OFFSET = 8;

  typedef struct packed {
    ptrc_action_t act;
    logic [31:0]  avail;
    logic [31:0]  seqw;
    logic         consume_ok;
    logic         write_ok;
  } ring_beat_t;

  typedef struct packed {
    ptrc_status_t status;
    logic         consumed;
    logic [7:0]   entry_index;
    logic [31:0]  entry_low;
    logic [31:0]  entry_high;
    logic         bell_write;
    logic [31:0]  bell_address;
    logic [7:0]   bell_value;
    logic [7:0]   next_index;
    logic [2:0]   expected_tag;
    logic [31:0]  seen_count;
    logic [31:0]  flush_count;
  } ring_result_t;

  class ring_consumer_ledger;
    // Register copies.
    logic [31:0]  bell_base;
    logic         count_en;
    // Ring state as the block should hold it after every accepted beat.
    logic [7:0]   pos;
    logic [2:0]   tag;
    logic [3:0]   pending;
    logic [7:0]   last_index;
    logic         last_valid;
    logic [31:0]  seen;
    logic [31:0]  forced;
    ring_result_t due_results[$];
    int           mismatches;

    function new();
      bell_base  = '0;
      count_en   = 1'b0;
      pos        = '0;
      tag        = '0;
      pending    = '0;
      last_index = '0;
      last_valid = 1'b0;
      seen       = '0;
      forced     = '0;
      mismatches = 0;
    endfunction

    function void write_reg(ptrc_cfg_idx_t idx, logic [31:0] data);
      if (idx == CFG_DOORBELL_BASE) begin
        bell_base = data;
      end else begin
        count_en = data[0];
      end
    endfunction

    // One doorbell attempt; returns 1 when the write went through.
    function bit ring_bell(logic ok, inout ring_result_t r);
      if (!last_valid) begin
        return 1'b0;
      end
      r.bell_write   = 1'b1;
      r.bell_address = bell_base + BELL_OFFSET;
      r.bell_value   = last_index;
      if (!ok) begin
        return 1'b0;
      end
      pending = '0;
      return 1'b1;
    endfunction

    function void note_beat(ring_beat_t b);
      ring_result_t r;
      logic [2:0]   seen_tag;
      r = '0;
      r.status = ST_OK;
      r.entry_index = pos;
      seen_tag = b.avail[TAG_MSB:TAG_LSB];
      if (b.act == ACT_FLUSH) begin
        if (pending != 0) begin
          if (ring_bell(b.write_ok, r)) begin
            forced = forced + 1;
          end else begin
            r.status = ST_DB_FAIL;
          end
        end
      end else if (pending >= PUBLISH_AT && !ring_bell(b.write_ok, r)) begin
        // Failed retry: the entry is not looked at.
        r.status = ST_DB_FAIL;
      end else if (seen_tag != tag) begin
        r.status = ST_UNAVAILABLE;
      end else begin
        if (count_en) begin
          seen = seen + 1;
        end
        r.entry_low  = b.seqw;
        r.entry_high = b.avail;
        if (!b.consume_ok) begin
          r.status = ST_REFUSED;
        end else begin
          last_index = pos;
          last_valid = 1'b1;
          if (int'(pos) + 1 >= RING_SIZE || pos == 8'hFF) begin
            pos = '0;
            tag = seen_tag + 3'd1;
          end else begin
            pos = pos + 8'd1;
          end
          pending = pending + 4'd1;
          r.consumed = 1'b1;
          if (pending >= PUBLISH_AT && !ring_bell(b.write_ok, r)) begin
            r.status = ST_DB_FAIL;
          end
        end
      end
      r.next_index   = pos;
      r.expected_tag = tag;
      r.seen_count   = seen;
      r.flush_count  = forced;
      due_results.push_back(r);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t want;
      if (due_results.size() == 0) begin
        $error("result beat arrived with nothing expected");
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      cmp_field("status", want.status, got.status);
      cmp_field("consumed", want.consumed, got.consumed);
      cmp_field("entry_index", want.entry_index, got.entry_index);
      cmp_field("entry_low", want.entry_low, got.entry_low);
      cmp_field("entry_high", want.entry_high, got.entry_high);
      cmp_field("doorbell_write", want.bell_write, got.bell_write);
      cmp_field("doorbell_address", want.bell_address, got.bell_address);
      cmp_field("doorbell_value", want.bell_value, got.bell_value);
      cmp_field("next_index", want.next_index, got.next_index);
      cmp_field("expected_tag", want.expected_tag, got.expected_tag);
      cmp_field("seen_count", want.seen_count, got.seen_count);
      cmp_field("flush_count", want.flush_count, got.flush_count);
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
// Top-level testbench for the phase-tagged ring consumer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ptrc_pkg::*;
  import tb_ring_ledger_pkg::*;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_we = 1'b0;
  ptrc_cfg_idx_t cfg_index = CFG_DOORBELL_BASE;
  logic [31:0]   cfg_data = '0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          in_action = ACT_CONSUME;
  logic [31:0]   in_availability_word = '0;
  logic [31:0]   in_sequence_word = '0;
  logic          in_consume_ok = 1'b0;
  logic          in_write_ok = 1'b0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [1:0]    out_status;
  logic          out_consumed;
  logic [7:0]    out_entry_index;
  logic [31:0]   out_entry_low;
  logic [31:0]   out_entry_high;
  logic          out_doorbell_write;
  logic [31:0]   out_doorbell_address;
  logic [7:0]    out_doorbell_value;
  logic [7:0]    out_next_index;
  logic [2:0]    out_expected_tag;
  logic [31:0]   out_seen_count;
  logic [31:0]   out_flush_count;

  ring_consumer_ledger ledger;
  int beats_sent = 0;
  int results_seen = 0;

  phase_tagged_ring_consumer #(
    .RING_DEPTH      (RING_SIZE),
    .PUBLISH_INTERVAL(PUBLISH_AT),
    .INDEX_OFFSET    (BELL_OFFSET)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_availability_word(in_availability_word),
    .in_sequence_word    (in_sequence_word),
    .in_consume_ok       (in_consume_ok),
    .in_write_ok         (in_write_ok),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_consumed        (out_consumed),
    .out_entry_index     (out_entry_index),
    .out_entry_low       (out_entry_low),
    .out_entry_high      (out_entry_high),
    .out_doorbell_write  (out_doorbell_write),
    .out_doorbell_address(out_doorbell_address),
    .out_doorbell_value  (out_doorbell_value),
    .out_next_index      (out_next_index),
    .out_expected_tag    (out_expected_tag),
    .out_seen_count      (out_seen_count),
    .out_flush_count     (out_flush_count)
  );

  always #6 clk = ~clk;

  // Receiver stall: drawn with about a 12 in 100 chance, except for a long steady
  // window of results where the output side never pushes back. Drive it on the
  // falling edge so it is settled at the sampling edge.
  always @(negedge clk) begin
    out_stall <= !(results_seen >= 300 && results_seen < 550) &&
                 ($urandom_range(0, 99) < 12);
  end

  // Take a result beat at the rising edge; values read here are the ones that
  // held during the cycle before the edge.
  always @(posedge clk) begin
    ring_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.status       = ptrc_status_t'(out_status);
      got.consumed     = out_consumed;
      got.entry_index  = out_entry_index;
      got.entry_low    = out_entry_low;
      got.entry_high   = out_entry_high;
      got.bell_write   = out_doorbell_write;
      got.bell_address = out_doorbell_address;
      got.bell_value   = out_doorbell_value;
      got.next_index   = out_next_index;
      got.expected_tag = out_expected_tag;
      got.seen_count   = out_seen_count;
      got.flush_count  = out_flush_count;
      ledger.check_result(got);
      results_seen++;
    end
  end

  // Called at a falling edge, returns at a falling edge; cfg_we is high for a single
  // cycle, so back-to-back writes never hit the same step twice.
  task automatic write_reg(ptrc_cfg_idx_t idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    ledger.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Send one beat. Called at a falling edge, returns at the falling edge after
  // the accept. Valid stays high into the next beat unless an idle gap is
  // drawn, so it is never lowered and raised in one step.
  task automatic send_beat(ring_beat_t b);
    if (!(beats_sent >= 600 && beats_sent < 850) && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid             <= 1'b1;
    in_action            <= b.act;
    in_availability_word <= b.avail;
    in_sequence_word     <= b.seqw;
    in_consume_ok        <= b.consume_ok;
    in_write_ok          <= b.write_ok;
    // Hold the payload until the block takes it.
    do @(posedge clk); while (in_stall);
    ledger.note_beat(b);
    beats_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait for every expected result. Each beat yields exactly one
  // result, so an empty queue means the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.due_results.size() != 0) @(negedge clk);
  endtask

  function automatic ring_beat_t mk_beat(ptrc_action_t act, logic [31:0] avail,
                                         logic [31:0] seqw, logic cok, logic wok);
    ring_beat_t b;
    b.act        = act;
    b.avail      = avail;
    b.seqw       = seqw;
    b.consume_ok = cok;
    b.write_ok   = wok;
    return b;
  endfunction

  // Mostly well-formed consumes carrying the tag the block is waiting for, so
  // the index walks the whole ring and wraps; the rest is flushes and noise.
  function automatic ring_beat_t random_beat();
    ring_beat_t b;
    int pick;
    pick = $urandom_range(0, 99);
    b = mk_beat(ACT_CONSUME, $urandom(), $urandom(),
                $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 80);
    if (pick < 8) begin
      b.act = ACT_FLUSH;
    end else if (pick < 18) begin
      b.act = ptrc_action_t'($urandom_range(0, 1));
    end else begin
      b.avail[TAG_MSB:TAG_LSB] = ledger.tag;
    end
    return b;
  endfunction

  task automatic run_directed();
    // Flush with nothing pending: no write.
    send_beat(mk_beat(ACT_FLUSH, 32'h0, 32'h0, 1'b1, 1'b1));
    // Tag mismatch: unavailable.
    send_beat(mk_beat(ACT_CONSUME, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1));
    // Matching tag but downstream refuses: only the seen count moves.
    send_beat(mk_beat(ACT_CONSUME, 32'h1FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1));
    // Seven accepts build up pending entries below the publish threshold.
    for (int i = 0; i < 7; i++) begin
      send_beat(mk_beat(ACT_CONSUME, 32'h0000_0000 | i, 32'h100 + i, 1'b1, 1'b1));
    end
    // Eighth accept triggers the doorbell, which fails.
    send_beat(mk_beat(ACT_CONSUME, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b0));
    // Retry before consume fails again: entry untouched.
    send_beat(mk_beat(ACT_CONSUME, 32'h0, 32'h5A5A_A5A5, 1'b1, 1'b0));
    // Retry succeeds, then the entry is accepted.
    send_beat(mk_beat(ACT_CONSUME, 32'h1FFF_FFFF, 32'hA5A5_5A5A, 1'b1, 1'b1));
    // Forced write fails, then succeeds, then finds nothing pending.
    send_beat(mk_beat(ACT_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0));
    send_beat(mk_beat(ACT_FLUSH, 32'h0, 32'h0, 1'b0, 1'b1));
    send_beat(mk_beat(ACT_FLUSH, 32'h0, 32'h0, 1'b1, 1'b1));
    drain();
    // Counting off, base at zero: a refused entry leaves the seen count alone.
    write_reg(CFG_COUNT_ENABLE, 32'h0);
    write_reg(CFG_DOORBELL_BASE, 32'h0);
    send_beat(mk_beat(ACT_CONSUME, 32'h0, 32'h1, 1'b0, 1'b1));
    send_beat(mk_beat(ACT_CONSUME, 32'h0, 32'h2, 1'b1, 1'b1));
    send_beat(mk_beat(ACT_FLUSH, 32'h0, 32'h0, 1'b1, 1'b1));
    drain();
  endtask

  initial begin
    ledger = new();
    // Hold reset, then release it at a falling edge.
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_reg(CFG_DOORBELL_BASE, 32'hBFFF_FFFF);
    write_reg(CFG_COUNT_ENABLE, 32'h1);
    run_directed();

    // Random phases, each under its own register setting; the sender waits for
    // every result before each reconfiguration.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_DOORBELL_BASE, 32'h0);
          write_reg(CFG_COUNT_ENABLE, 32'h1);
        end
        1: begin
          write_reg(CFG_DOORBELL_BASE, 32'hBFFF_FFFF);
          write_reg(CFG_COUNT_ENABLE, 32'h0);
        end
        2: begin
          write_reg(CFG_DOORBELL_BASE, $urandom_range(0, 32'hBFFF_FFFF) & ~32'h3);
          write_reg(CFG_COUNT_ENABLE, $urandom_range(0, 1));
        end
        default: begin
          write_reg(CFG_DOORBELL_BASE, $urandom_range(0, 32'hBFFF_FFFF));
          write_reg(CFG_COUNT_ENABLE, 32'h1);
        end
      endcase
      repeat (338) send_beat(random_beat());
      drain();
    end

    // Wait so that any stray result beat can still show.
    repeat (10) @(negedge clk);
    if (ledger.due_results.size() != 0) begin
      $error("%0d expected results never arrived", ledger.due_results.size());
      ledger.mismatches++;
    end
    if (ledger.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #(2_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
